FILE: rtl/tfti_pkg.sv
`timescale 1ns / 1ps

package tfti_pkg;

   localparam int TFTI_MAX_GLYPHS     = 128;
   localparam int TFTI_MAX_FONT_BYTES = 65536;

   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_DASH = 8'h2d;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_EQ   = 8'h3d;
   localparam logic [7:0] CH_STAR = 8'h2a;

   localparam logic CMD_TABLE_BYTE = 1'b0;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [7:0]  code;
      logic [15:0] start;
      logic [7:0]  cols;
      logic [7:0]  rows;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic    done;
      logic    found;
      rec_type rec;
   } lu_result_type;

endpackage

FILE: rtl/tfti_ram.sv
`timescale 1ns / 1ps

module tfti_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tfti_parser.sv
`timescale 1ns / 1ps

module tfti_parser #(
   parameter int MAX_GLYPHS     = 128,
   parameter int MAX_FONT_BYTES = 65536
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic                                       first_byte,
   input  logic [7:0]                                 symbol,
   output logic [1:0]                                 status,
   output logic [$clog2(MAX_GLYPHS + 1)-1:0]          glyph_count,
   output logic [$clog2(MAX_GLYPHS + 1)-1:0]          glyph_count_next,
   output logic                                       wr_en,
   output logic [((MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1)-1:0] wr_addr,
   output tfti_pkg::rec_type                          wr_data
);
   import tfti_pkg::*;

   localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
   localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam int POS_W = $clog2(MAX_FONT_BYTES + 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_CODE  = 2'd1;
   localparam logic [1:0] PH_FIRST = 2'd2;
   localparam logic [1:0] PH_BODY  = 2'd3;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       colcnt_ff, colcnt_in;
   logic [7:0]       rows_ff, rows_in;
   logic             err_ff, err_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [7:0]       code_ff, code_in;
   logic [15:0]      start_ff, start_in;
   logic [7:0]       cols_ff, cols_in;

   logic             clr;
   logic             is_pixel, is_row_end;
   logic [31:0]      start_sum;
   logic [31:0]      count_ext;
   logic [7:0]       col_inc;

   assign clr        = en && first_byte;
   assign is_pixel   = (symbol == CH_DASH) || (symbol == CH_X);
   assign is_row_end = (symbol == CH_EQ) || (symbol == CH_STAR);
   assign col_inc    = (colcnt_ff == 8'hff) ? 8'hff : colcnt_ff + 8'd1;

   always_comb begin
      count_in  = clr ? '0 : count_ff;
      pos_in    = clr ? '0 : pos_ff;
      phase_in  = clr ? PH_IDLE : phase_ff;
      colcnt_in = clr ? 8'd0 : colcnt_ff;
      rows_in   = clr ? 8'd0 : rows_ff;
      err_in    = clr ? 1'b0 : err_ff;
      cur_in    = cur_ff;
      code_in   = code_ff;
      start_in  = start_ff;
      cols_in   = cols_ff;
      status    = ST_OK;
      wr_en     = 1'b0;
      start_sum = 32'(pos_in) + 32'd2;
      count_ext = 32'(count_in);
      if (en) begin
         if (err_in) begin
            status = ST_MALFORMED;
         end else if (pos_in != POS_W'(MAX_FONT_BYTES)) begin
            pos_in = pos_in + 1'b1;
            if (phase_in == PH_CODE) begin
               code_in  = symbol;
               phase_in = PH_FIRST;
               wr_en    = 1'b1;
            end else if (phase_in == PH_FIRST && !is_pixel) begin
               err_in   = 1'b1;
               phase_in = PH_IDLE;
               status   = ST_MALFORMED;
            end else if (symbol == CH_AT) begin
               if (count_in == CNT_W'(MAX_GLYPHS)) begin
                  phase_in = PH_IDLE;
                  status   = ST_FULL;
               end else begin
                  cur_in    = count_ext[IDX_W-1:0];
                  count_in  = count_in + 1'b1;
                  code_in   = 8'd0;
                  start_in  = (start_sum > 32'd65535) ? 16'hffff : start_sum[15:0];
                  cols_in   = 8'd0;
                  colcnt_in = 8'd0;
                  rows_in   = 8'd0;
                  phase_in  = PH_CODE;
                  wr_en     = 1'b1;
               end
            end else if (phase_in != PH_IDLE) begin
               if (is_pixel) begin
                  cols_in   = col_inc;
                  colcnt_in = col_inc;
                  phase_in  = PH_BODY;
                  wr_en     = 1'b1;
               end else if (is_row_end) begin
                  cols_in   = col_inc;
                  colcnt_in = 8'd0;
                  rows_in   = (rows_in == 8'hff) ? 8'hff : rows_in + 8'd1;
                  phase_in  = PH_BODY;
                  wr_en     = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pos_ff    <= '0;
         phase_ff  <= PH_IDLE;
         colcnt_ff <= 8'd0;
         rows_ff   <= 8'd0;
         err_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         colcnt_ff <= colcnt_in;
         rows_ff   <= rows_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      code_ff  <= code_in;
      start_ff <= start_in;
      cols_ff  <= cols_in;
   end

   assign glyph_count      = count_ff;
   assign glyph_count_next = count_in;
   assign wr_addr          = cur_in;
   assign wr_data          = '{code: code_in, start: start_in, cols: cols_in, rows: rows_in};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_GLYPHS))
      else $error("glyph count beyond capacity");

   a_write_open: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (phase_in != PH_IDLE) && (count_in != '0))
      else $error("record write with no record open");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff && !(en && first_byte)) |=> err_ff)
      else $error("malformed flag dropped without a new table");

endmodule

FILE: rtl/tfti_lookup.sv
`timescale 1ns / 1ps

module tfti_lookup #(
   parameter int MAX_GLYPHS = 128
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [7:0]                                 symbol,
   input  logic [$clog2(MAX_GLYPHS + 1)-1:0]          glyph_count,
   input  logic [6:0]                                 default_glyph,
   input  tfti_pkg::rec_type                          rd_data,
   output logic [((MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1)-1:0] rd_addr,
   output logic                                       busy,
   output tfti_pkg::lu_result_type                    result
);
   import tfti_pkg::*;

   localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
   localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

   localparam logic [1:0] LU_IDLE  = 2'd0;
   localparam logic [1:0] LU_SCAN  = 2'd1;
   localparam logic [1:0] LU_DFLT  = 2'd2;
   localparam logic [1:0] LU_DWAIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             chk_ff, chk_in;
   logic [7:0]       sym_ff, sym_in;

   logic [CNT_W-1:0] last_cnt;
   logic [IDX_W-1:0] last_idx;
   logic [31:0]      dflt_ext;
   logic             dflt_ok;
   logic             hit;

   assign last_cnt = glyph_count - 1'b1;
   assign last_idx = last_cnt[IDX_W-1:0];
   assign dflt_ext = 32'(default_glyph);
   assign dflt_ok  = dflt_ext < 32'(glyph_count);
   assign hit      = (rd_data.code == sym_ff);

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      chk_idx_in = chk_idx_ff;
      chk_in     = chk_ff;
      sym_in     = sym_ff;
      rd_addr    = scan_ff;
      result     = '0;
      case (state_ff)
         LU_IDLE: begin
            if (start) begin
               sym_in  = symbol;
               scan_in = '0;
               chk_in  = 1'b0;
               state_in = (glyph_count == '0) ? LU_DFLT : LU_SCAN;
            end
         end
         LU_SCAN: begin
            chk_in     = 1'b1;
            chk_idx_in = scan_ff;
            if (scan_ff != last_idx) begin
               scan_in = scan_ff + 1'b1;
            end
            if (chk_ff) begin
               if (hit) begin
                  result.done  = 1'b1;
                  result.found = 1'b1;
                  result.rec   = rd_data;
                  state_in     = LU_IDLE;
               end else if (chk_idx_ff == last_idx) begin
                  state_in = LU_DFLT;
               end
            end
         end
         LU_DFLT: begin
            rd_addr = dflt_ext[IDX_W-1:0];
            if (dflt_ok) begin
               state_in = LU_DWAIT;
            end else begin
               result.done = 1'b1;
               state_in    = LU_IDLE;
            end
         end
         LU_DWAIT: begin
            result.done = 1'b1;
            result.rec  = rd_data;
            state_in    = LU_IDLE;
         end
         default: begin
            state_in = LU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LU_IDLE;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      sym_ff     <= sym_in;
   end

   assign busy = (state_ff != LU_IDLE);

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      result.done |-> busy)
      else $error("lookup result outside a lookup");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LU_SCAN) |-> (32'(scan_ff) < 32'(glyph_count)))
      else $error("scan beyond stored records");

endmodule

FILE: rtl/text_font_table_indexer.sv
`timescale 1ns / 1ps

// Font table indexer. Table bytes (command 0) build an index of glyph records as they stream
// in: '@' opens a record, the next byte is its character code, '-' and 'x' are pixels and
// '=' and '*' end a row. A table byte is answered in the cycle after it is taken. A lookup
// (command 1) walks the stored records through the single read port of the record memory,
// one record compared per cycle, and returns the first match; on a miss it reads slot
// default_glyph and returns that record with a not-found status, or, when that slot holds
// no record or the table is empty, a not-found status with zero record fields and no read.
// No new request is taken while a lookup runs. The answer sits in an output register, and
// the next request is taken in the cycle that the answer leaves it.
module text_font_table_indexer #(
   parameter int MAX_GLYPHS     = tfti_pkg::TFTI_MAX_GLYPHS,
   parameter int MAX_FONT_BYTES = tfti_pkg::TFTI_MAX_FONT_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_first_byte,
   input  logic [7:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_glyph_total,
   output logic [15:0] rsp_pattern_start,
   output logic [7:0]  rsp_column_total,
   output logic [7:0]  rsp_row_total,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import tfti_pkg::*;

   localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
   localparam int IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

   logic             req_accept;
   logic             byte_en, lu_start;
   logic [1:0]       p_status;
   logic [CNT_W-1:0] count, count_next;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   rec_type          wr_data, rd_data;
   logic [REC_W-1:0] rd_raw;
   logic             lu_busy;
   lu_result_type    lu_res;
   logic             rsp_load;
   logic [31:0]      total_ext;

   logic [6:0]  dflt_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  total_ff, total_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  cols_ff, cols_in;
   logic [7:0]  rows_ff, rows_in;

   assign req_stall  = lu_busy || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign byte_en    = req_accept && (req_command == CMD_TABLE_BYTE);
   assign lu_start   = req_accept && (req_command != CMD_TABLE_BYTE);

   tfti_parser #(
      .MAX_GLYPHS     (MAX_GLYPHS),
      .MAX_FONT_BYTES (MAX_FONT_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .en               (byte_en),
      .first_byte       (req_first_byte),
      .symbol           (req_symbol),
      .status           (p_status),
      .glyph_count      (count),
      .glyph_count_next (count_next),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   tfti_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_GLYPHS)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data = rec_type'(rd_raw);

   tfti_lookup #(
      .MAX_GLYPHS (MAX_GLYPHS)
   ) u_lookup (
      .clock         (clock),
      .reset         (reset),
      .start         (lu_start),
      .symbol        (req_symbol),
      .glyph_count   (count),
      .default_glyph (dflt_ff),
      .rd_data       (rd_data),
      .rd_addr       (rd_addr),
      .busy          (lu_busy),
      .result        (lu_res)
   );

   assign rsp_load = byte_en || lu_res.done;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      total_ext    = byte_en ? 32'(count_next) : 32'(count);
      if (byte_en) begin
         rsp_valid_in = 1'b1;
         status_in    = p_status;
         total_in     = total_ext[7:0];
         start_in     = 16'd0;
         cols_in      = 8'd0;
         rows_in      = 8'd0;
      end else if (lu_res.done) begin
         rsp_valid_in = 1'b1;
         status_in    = lu_res.found ? ST_OK : ST_NOT_FOUND;
         total_in     = total_ext[7:0];
         start_in     = lu_res.rec.start;
         cols_in      = lu_res.rec.cols;
         rows_in      = lu_res.rec.rows;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dflt_ff      <= 7'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dflt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      total_ff  <= total_in;
      start_ff  <= start_in;
      cols_ff   <= cols_in;
      rows_ff   <= rows_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_glyph_total   = total_ff;
   assign rsp_pattern_start = start_ff;
   assign rsp_column_total  = cols_ff;
   assign rsp_row_total     = rows_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("held answer overwritten");

endmodule

FILE: test/font_index_checker.sv
`timescale 1ns / 1ps

module font_index_checker
   import tfti_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  logic         req_command,
   input  logic         req_first_byte,
   input  logic [7:0]   req_symbol,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic [1:0]   rsp_status,
   input  logic [7:0]   rsp_glyph_total,
   input  logic [15:0]  rsp_pattern_start,
   input  logic [7:0]   rsp_column_total,
   input  logic [7:0]   rsp_row_total,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data,
   output int           fail_total,
   output int           answers_pending,
   output int           glyphs_indexed,
   output logic [255:0] codes_indexed
);

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_CODE, SCAN_FIRST, SCAN_BODY} scan_phase_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  total;
      logic [15:0] start;
      logic [7:0]  cols;
      logic [7:0]  rows;
   } answer_t;

   rec_type     glyph_index [TFTI_MAX_GLYPHS];
   int          glyphs;
   int          position;
   scan_phase_t phase;
   int          run_cols;
   int          run_rows;
   bit          malformed;
   logic [6:0]  default_slot;
   int          mismatches;
   answer_t     answers_due [$];
   answer_t     want;

   function automatic bit is_pixel(logic [7:0] b);
      return b == CH_DASH || b == CH_X;
   endfunction

   function automatic bit is_row_end(logic [7:0] b);
      return b == CH_EQ || b == CH_STAR;
   endfunction

   function automatic int sat_count(int v);
      return (v > 255) ? 255 : v;
   endfunction

   function automatic void clear_index();
      int i;
      for (i = 0; i < TFTI_MAX_GLYPHS; i++) glyph_index[i] = '0;
      glyphs = 0;
      position = 0;
      phase = SCAN_IDLE;
      run_cols = 0;
      run_rows = 0;
      malformed = 1'b0;
   endfunction

   function automatic logic [1:0] index_byte(logic [7:0] b);
      int here;
      int slot;
      here = position;
      slot = glyphs - 1;
      if (malformed) return ST_MALFORMED;
      if (here >= TFTI_MAX_FONT_BYTES) return ST_OK;
      position = here + 1;
      if (phase == SCAN_CODE) begin
         glyph_index[slot].code = b;
         phase = SCAN_FIRST;
         return ST_OK;
      end
      if (phase == SCAN_FIRST && !is_pixel(b)) begin
         malformed = 1'b1;
         phase = SCAN_IDLE;
         return ST_MALFORMED;
      end
      if (b == CH_AT) begin
         if (glyphs >= TFTI_MAX_GLYPHS) begin
            phase = SCAN_IDLE;
            return ST_FULL;
         end
         glyph_index[glyphs] = '0;
         glyph_index[glyphs].start = (here + 2 > 65535) ? 16'hffff : 16'(here + 2);
         glyphs++;
         run_cols = 0;
         run_rows = 0;
         phase = SCAN_CODE;
         return ST_OK;
      end
      if (phase == SCAN_IDLE) return ST_OK;
      if (is_pixel(b)) begin
         run_cols = sat_count(run_cols + 1);
         glyph_index[slot].cols = 8'(run_cols);
         phase = SCAN_BODY;
      end else if (is_row_end(b)) begin
         glyph_index[slot].cols = 8'(sat_count(run_cols + 1));
         run_cols = 0;
         run_rows = sat_count(run_rows + 1);
         glyph_index[slot].rows = 8'(run_rows);
         phase = SCAN_BODY;
      end
      return ST_OK;
   endfunction

   function automatic answer_t predict_answer(logic cmd, logic first, logic [7:0] sym);
      answer_t a;
      rec_type r;
      bit      hit;
      int      i;
      a = '0;
      if (cmd == CMD_TABLE_BYTE) begin
         if (first) clear_index();
         a.status = index_byte(sym);
      end else begin
         r = '0;
         hit = 1'b0;
         for (i = 0; i < glyphs && i < TFTI_MAX_GLYPHS && !hit; i++) begin
            if (glyph_index[i].code == sym) begin
               r = glyph_index[i];
               hit = 1'b1;
            end
         end
         if (!hit && default_slot < TFTI_MAX_GLYPHS) r = glyph_index[default_slot];
         a.status = hit ? ST_OK : ST_NOT_FOUND;
         a.start = r.start;
         a.cols = r.cols;
         a.rows = r.rows;
      end
      a.total = 8'(glyphs);
      return a;
   endfunction

   function automatic logic [255:0] presence_of_codes();
      logic [255:0] seen;
      int           i;
      seen = '0;
      for (i = 0; i < glyphs; i++) seen[glyph_index[i].code] = 1'b1;
      return seen;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 100) $display("checker: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] expected, logic [15:0] got);
      if (got !== expected)
         report_mismatch($sformatf("%s expected %0d, got %0d (request %0d outstanding)",
                                   name, expected, got, answers_due.size()));
   endtask

   initial begin
      mismatches = 0;
      default_slot = '0;
      clear_index();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_index();
         default_slot = '0;
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = answers_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("glyph_total", want.total, rsp_glyph_total);
               check_field("pattern_start", want.start, rsp_pattern_start);
               check_field("column_total", want.cols, rsp_column_total);
               check_field("row_total", want.rows, rsp_row_total);
            end
         end
         if (csr_wr_en) default_slot = csr_wr_data;
         if (req_valid && !req_stall)
            answers_due.push_back(predict_answer(req_command, req_first_byte, req_symbol));
      end
      fail_total <= mismatches;
      answers_pending <= answers_due.size();
      glyphs_indexed <= glyphs;
      codes_indexed <= presence_of_codes();
   end

endmodule

FILE: test/text_font_table_indexer_tb.sv
`timescale 1ns / 1ps

module text_font_table_indexer_tb;
   import tfti_pkg::*;

   localparam int   CYCLE_LIMIT   = 3000000;
   localparam int   SETTLE_CYCLES = 140;
   localparam int   PHASE_ITEMS   = 60;
   localparam logic CMD_LOOKUP    = ~CMD_TABLE_BYTE;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic         req_command;
   logic         req_first_byte;
   logic [7:0]   req_symbol;
   logic         rsp_valid;
   logic         rsp_stall;
   logic [1:0]   rsp_status;
   logic [7:0]   rsp_glyph_total;
   logic [15:0]  rsp_pattern_start;
   logic [7:0]   rsp_column_total;
   logic [7:0]   rsp_row_total;
   logic         csr_wr_en;
   logic [6:0]   csr_wr_data;

   int           fail_total;
   int           answers_pending;
   int           glyphs_indexed;
   logic [255:0] codes_indexed;

   int           idle_pct;
   int           stall_pct;
   int           requests_sent;
   int           default_now;
   int           cycles;

   text_font_table_indexer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_first_byte    (req_first_byte),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_glyph_total   (rsp_glyph_total),
      .rsp_pattern_start (rsp_pattern_start),
      .rsp_column_total  (rsp_column_total),
      .rsp_row_total     (rsp_row_total),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   font_index_checker answer_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_first_byte    (req_first_byte),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_glyph_total   (rsp_glyph_total),
      .rsp_pattern_start (rsp_pattern_start),
      .rsp_column_total  (rsp_column_total),
      .rsp_row_total     (rsp_row_total),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_total        (fail_total),
      .answers_pending   (answers_pending),
      .glyphs_indexed    (glyphs_indexed),
      .codes_indexed     (codes_indexed)
   );

   always #5 clock = ~clock;

   always @(negedge clock) rsp_stall = ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic next_slot();
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic present(logic cmd, logic first, logic [7:0] sym);
      req_valid = 1'b1;
      req_command = cmd;
      req_first_byte = first;
      req_symbol = sym;
      requests_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_req(logic cmd, logic first, logic [7:0] sym);
      next_slot();
      present(cmd, first, sym);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (answers_pending != 0) @(negedge clock);
   endtask

   task automatic set_default_slot(int slot);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = 7'(slot);
      default_now = slot;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // a miss may only land on a slot of the current table
   task automatic send_lookup_safe();
      logic [7:0] sym;
      int         base;
      int         k;
      next_slot();
      sym = 8'($urandom_range(255));
      if (glyphs_indexed == 0) begin
         present(CMD_TABLE_BYTE, 1'b0, sym);
         return;
      end
      if ((!codes_indexed[sym] && glyphs_indexed <= default_now) || $urandom_range(99) < 60) begin
         base = $urandom_range(255);
         for (k = 0; k < 256; k++) begin
            if (codes_indexed[8'(base + k)]) sym = 8'(base + k);
         end
      end
      present(CMD_LOOKUP, 1'($urandom_range(1)), sym);
   endtask

   task automatic send_record(bit fresh);
      int rows;
      int n;
      int r;
      int k;
      send_req(CMD_TABLE_BYTE, fresh, CH_AT);
      if ($urandom_range(99) < 70) send_req(CMD_TABLE_BYTE, 1'b0, 8'(8'h41 + $urandom_range(7)));
      else send_req(CMD_TABLE_BYTE, 1'b0, 8'($urandom_range(255)));
      if ($urandom_range(99) < 6) begin
         send_req(CMD_TABLE_BYTE, 1'b0, $urandom_range(1) ? CH_EQ : 8'($urandom_range(255)));
         return;
      end
      rows = $urandom_range(1, 4);
      for (r = 0; r < rows; r++) begin
         n = $urandom_range(r == 0 ? 1 : 0, 5);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 4) send_req(CMD_TABLE_BYTE, 1'b0, 8'($urandom_range(255)));
            send_req(CMD_TABLE_BYTE, 1'b0, $urandom_range(1) ? CH_DASH : CH_X);
         end
         if ($urandom_range(99) < 90)
            send_req(CMD_TABLE_BYTE, 1'b0, $urandom_range(1) ? CH_EQ : CH_STAR);
      end
   endtask

   initial begin
      int ph;
      int i;
      int goal;
      int pick;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TABLE_BYTE;
      req_first_byte = 1'b0;
      req_symbol = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      requests_sent = 0;
      default_now = 0;
      cycles = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // short directed run: stray pixel, two glyphs, lookups, a malformed record
      set_default_slot(0);
      send_req(CMD_TABLE_BYTE, 1'b1, CH_DASH);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, 8'hff);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_X);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_DASH);
      send_req(CMD_TABLE_BYTE, 1'b0, "q");
      send_req(CMD_TABLE_BYTE, 1'b0, CH_EQ);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_X);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_STAR);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, 8'h00);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_DASH);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_STAR);
      send_req(CMD_LOOKUP, 1'b1, 8'hff);
      send_req(CMD_LOOKUP, 1'b0, 8'h00);
      send_req(CMD_LOOKUP, 1'b0, "Z");
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, "C");
      send_req(CMD_TABLE_BYTE, 1'b0, CH_EQ);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_X);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_LOOKUP, 1'b0, "C");

      // fill the table, then one glyph too many
      for (i = 0; i < TFTI_MAX_GLYPHS; i++) begin
         send_req(CMD_TABLE_BYTE, i == 0, CH_AT);
         send_req(CMD_TABLE_BYTE, 1'b0, 8'($urandom_range(255)));
         send_req(CMD_TABLE_BYTE, 1'b0, CH_DASH);
      end
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_X);
      set_default_slot(TFTI_MAX_GLYPHS - 1);
      send_req(CMD_LOOKUP, 1'b0, 8'hff);
      for (i = 0; i < 8; i++) send_lookup_safe();

      // saturating counts
      set_default_slot(1);
      send_req(CMD_TABLE_BYTE, 1'b1, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, "S");
      for (i = 0; i < 260; i++) send_req(CMD_TABLE_BYTE, 1'b0, CH_X);
      send_req(CMD_LOOKUP, 1'b0, "S");
      for (i = 0; i < 260; i++) send_req(CMD_TABLE_BYTE, 1'b0, CH_EQ);
      send_req(CMD_LOOKUP, 1'b0, "S");
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, "T");
      send_req(CMD_TABLE_BYTE, 1'b0, CH_DASH);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_AT);
      send_req(CMD_TABLE_BYTE, 1'b0, CH_X);
      send_req(CMD_LOOKUP, 1'b0, "T");
      send_req(CMD_LOOKUP, 1'b0, "S");
      send_req(CMD_LOOKUP, 1'b0, 8'h01);

      // random tables under each idling pattern
      for (ph = 0; ph < 4; ph++) begin
         set_default_slot(ph == 3 ? 0 : $urandom_range(1, 3));
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 66; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 66; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         send_record(1'b1);
         goal = requests_sent + PHASE_ITEMS;
         while (requests_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 45) send_record(glyphs_indexed >= 48 || pick < 4);
            else if (pick < 80) send_lookup_safe();
            else if (pick < 97)
               send_req(CMD_TABLE_BYTE, $urandom_range(99) < 3, 8'($urandom_range(255)));
            else drain();
         end
      end

      drain();
      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_total == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tfti_pkg.sv
rtl/tfti_ram.sv
rtl/tfti_parser.sv
rtl/tfti_lookup.sv
rtl/text_font_table_indexer.sv
test/font_index_checker.sv
test/text_font_table_indexer_tb.sv
